@@ sv/bkda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bkda_pkg;

    localparam int VW = 40;            // binary value and operand width
    localparam int FIELD_NIBBLES = 10; // nibbles that fit in a 40-bit field
    localparam int IDXW = 4;           // digit index width in the command
    localparam logic [3:0] BASE_MIN = 4'd2;
    localparam logic [3:0] BASE_MAX = 4'd10;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_SUB     = 3'd1;
    localparam logic [2:0] OP_MUL     = 3'd2;
    localparam logic [2:0] OP_DIV     = 3'd3;
    localparam logic [2:0] OP_DIG2BIN = 3'd4;
    localparam logic [2:0] OP_BIN2DIG = 3'd5;
    localparam logic [2:0] OP_CONV    = 3'd6;
    localparam logic [2:0] OP_UNUSED  = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_NEG  = 2'd3;

    localparam logic CFG_RADIX  = 1'b0;
    localparam logic CFG_TARGET = 1'b1;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_POW,
        CMD_UNPACK,
        CMD_ADD,
        CMD_SUB,
        CMD_MUL,
        CMD_DIV,
        CMD_TAKE_VA,
        CMD_TAKE_A,
        CMD_CHECK,
        CMD_DIGIT,
        CMD_PUBLISH
    } cmd_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [IDXW-1:0] idx;
    } ctrl_t;

    typedef struct packed {
        logic [2:0] op;
        logic       err;
        logic       ge;
    } stat_t;

    function automatic logic [3:0] clamp_base(input logic [3:0] r);
        logic [3:0] k;
        k = r;
        if (r < BASE_MIN)
            k = BASE_MIN;
        else if (r > BASE_MAX)
            k = BASE_MAX;
        return k;
    endfunction

endpackage
`default_nettype wire

@@ sv/base_k_digit_arithmetic_unit.sv @@
// Radix-K digit arithmetic unit.
// Requests arrive on the s_axis channel: op, operand_a and operand_b packed in
// tdata. Results leave on the m_axis channel: result and status in tdata.
// The base registers (radix, target_radix) are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no request is
// in flight, as the block itself does not enforce this.
// One request is worked on at a time. It passes through CAP power steps, CAP
// unpack steps (skipped for binary-to-digits), then the add, subtract or
// pass-through operation, or a bit-serial multiply or divide (one bit per
// cycle), then a range check and a digit sweep, in which each digit is found
// by repeated subtraction of its power (digits-to-binary and the unused op
// skip both, and an error ends the sweep), and then a publish step. CAP is
// min(DIGITS, 10). The bit-serial multiply/divide loop and the digit sweep are
// the longest parts of a request. A new request is taken in the cycle after
// the previous result has been placed in the output register, even while that
// result still waits. If the receiver stalls, the next result waits in the
// controller until the output register is free. Reset returns the bases to 10
// and 2 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module base_k_digit_arithmetic_unit
    import bkda_pkg::*;
#(
    parameter int DIGITS = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,  // op[2:0], operand_a[42:3], operand_b[82:43]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // result[39:0], status[41:40]
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data
);

    localparam int CAP = (DIGITS < FIELD_NIBBLES) ? DIGITS : FIELD_NIBBLES;

    ctrl_t         ctrl;
    stat_t         stat;
    logic [VW-1:0] result;
    logic [1:0]    status;

    bkda_controller #(.CAP(CAP)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    bkda_datapath #(.CAP(CAP)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_op      (s_axis_tdata[2:0]),
        .in_a       (s_axis_tdata[42:3]),
        .in_b       (s_axis_tdata[82:43]),
        .ctrl       (ctrl),
        .stat       (stat),
        .out_result (result),
        .out_status (status)
    );

    assign m_axis_tdata = {6'd0, status, result};

endmodule
`default_nettype wire

@@ sv/bkda_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bkda_datapath
    import bkda_pkg::*;
#(
    parameter int CAP = 10
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [3:0]    cfg_data,
    input  wire logic [2:0]    in_op,
    input  wire logic [VW-1:0] in_a,
    input  wire logic [VW-1:0] in_b,
    input  wire ctrl_t         ctrl,
    output stat_t              stat,
    output logic [VW-1:0]      out_result,
    output logic [1:0]         out_status
);

    localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;

    logic [3:0]    radix_reg;
    logic [3:0]    target_reg;
    logic [2:0]    op_reg;
    logic [VW-1:0] a_reg;
    logic [VW-1:0] b_reg;
    logic [3:0]    k_reg;
    logic [3:0]    kp_reg;
    logic [VW-1:0] va_reg;
    logic [VW-1:0] vb_reg;
    logic [VW-1:0] val_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] p_reg;
    logic [VW-1:0] res_reg;
    logic [3:0]    d_reg;
    logic [1:0]    err_reg;
    logic [VW-1:0] pow_reg [CAP];
    logic [VW-1:0] out_result_reg;
    logic [1:0]    out_status_reg;

    logic [VW-1:0] pow_sel;
    logic [VW-1:0] macc;
    logic [VW-1:0] r2;

    assign pow_sel = pow_reg[ctrl.idx[IW-1:0]];
    assign macc = {val_reg[VW-2:0], 1'b0} + (vb_reg[VW-1] ? va_reg : '0);
    assign r2 = {rem_reg[VW-2:0], va_reg[VW-1]};

    assign stat.op  = op_reg;
    assign stat.err = (err_reg != ST_OK);
    assign stat.ge  = (val_reg >= pow_sel);

    assign out_result = out_result_reg;
    assign out_status = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= 4'd10;
            target_reg <= 4'd2;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RADIX)
                radix_reg <= cfg_data;
            else
                target_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            CMD_LOAD:
            begin
                op_reg  <= in_op;
                a_reg   <= in_a;
                b_reg   <= in_b;
                k_reg   <= clamp_base(radix_reg);
                kp_reg  <= (in_op == OP_CONV) ? clamp_base(target_reg)
                                              : clamp_base(radix_reg);
                va_reg  <= '0;
                vb_reg  <= '0;
                val_reg <= '0;
                rem_reg <= '0;
                p_reg   <= VW'(1);
                res_reg <= '0;
                d_reg   <= '0;
                err_reg <= ST_OK;
            end
            CMD_POW:
            begin
                pow_reg[ctrl.idx[IW-1:0]] <= p_reg;
                p_reg <= p_reg * VW'(kp_reg);
            end
            CMD_UNPACK:
            begin
                // Horner step, most significant digit first.
                va_reg <= va_reg * VW'(k_reg) + VW'(a_reg[4*CAP-1 -: 4]);
                vb_reg <= vb_reg * VW'(k_reg) + VW'(b_reg[4*CAP-1 -: 4]);
                a_reg  <= {a_reg[VW-5:0], 4'd0};
                b_reg  <= {b_reg[VW-5:0], 4'd0};
            end
            CMD_ADD:
                val_reg <= va_reg + vb_reg;
            CMD_SUB:
            begin
                if (vb_reg > va_reg)
                    err_reg <= ST_NEG;
                else
                    val_reg <= va_reg - vb_reg;
            end
            CMD_MUL:
            begin
                // The partial product only grows, so once past the limit it stays past.
                vb_reg <= {vb_reg[VW-2:0], 1'b0};
                if (err_reg == ST_OK)
                begin
                    if (macc >= p_reg)
                        err_reg <= ST_OVF;
                    else
                        val_reg <= macc;
                end
            end
            CMD_DIV:
            begin
                va_reg <= {va_reg[VW-2:0], 1'b0};
                if (vb_reg == '0)
                    err_reg <= ST_DIVZ;
                if (r2 >= vb_reg)
                begin
                    rem_reg <= r2 - vb_reg;
                    val_reg <= {val_reg[VW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2;
                    val_reg <= {val_reg[VW-2:0], 1'b0};
                end
            end
            CMD_TAKE_VA:
                val_reg <= va_reg;
            CMD_TAKE_A:
                val_reg <= a_reg;
            CMD_CHECK:
            begin
                if (err_reg == ST_OK && val_reg >= p_reg)
                    err_reg <= ST_OVF;
            end
            CMD_DIGIT:
            begin
                if (val_reg >= pow_sel)
                begin
                    val_reg <= val_reg - pow_sel;
                    d_reg   <= d_reg + 4'd1;
                end
                else
                begin
                    res_reg <= {res_reg[VW-5:0], d_reg};
                    d_reg   <= '0;
                end
            end
            CMD_PUBLISH:
            begin
                if (err_reg != ST_OK)
                    out_result_reg <= '0;
                else if (op_reg == OP_DIG2BIN || op_reg == OP_UNUSED)
                    out_result_reg <= val_reg;
                else
                    out_result_reg <= res_reg;
                out_status_reg <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/bkda_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bkda_controller
    import bkda_pkg::*;
#(
    parameter int CAP = 10
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    localparam int STEPS = VW;
    localparam int CW = $clog2(STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POW,
        S_UNPACK,
        S_EXEC,
        S_CHECK,
        S_DIGIT,
        S_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    cmd_t          cmd;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign ctrl.cmd  = cmd;
    assign ctrl.idx  = cnt_reg[IDXW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = CMD_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    cnt_next   = '0;
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                cmd = CMD_POW;
                if (cnt_reg == CW'(CAP - 1))
                begin
                    cnt_next   = '0;
                    state_next = (stat.op == OP_BIN2DIG) ? S_EXEC : S_UNPACK;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_UNPACK:
            begin
                cmd = CMD_UNPACK;
                if (cnt_reg == CW'(CAP - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_EXEC;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_EXEC:
            begin
                case (stat.op)
                    OP_ADD:
                    begin
                        cmd        = CMD_ADD;
                        state_next = S_CHECK;
                    end
                    OP_SUB:
                    begin
                        cmd        = CMD_SUB;
                        state_next = S_CHECK;
                    end
                    OP_MUL, OP_DIV:
                    begin
                        cmd = (stat.op == OP_MUL) ? CMD_MUL : CMD_DIV;
                        if (cnt_reg == CW'(STEPS - 1))
                        begin
                            cnt_next   = '0;
                            state_next = S_CHECK;
                        end
                        else
                            cnt_next = cnt_reg + CW'(1);
                    end
                    OP_DIG2BIN:
                    begin
                        cmd        = CMD_TAKE_VA;
                        state_next = S_FINISH;
                    end
                    OP_BIN2DIG:
                    begin
                        cmd        = CMD_TAKE_A;
                        state_next = S_CHECK;
                    end
                    OP_CONV:
                    begin
                        cmd        = CMD_TAKE_VA;
                        state_next = S_CHECK;
                    end
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_CHECK:
            begin
                cmd        = CMD_CHECK;
                cnt_next   = CW'(CAP - 1);
                state_next = S_DIGIT;
            end
            S_DIGIT:
            begin
                if (stat.err)
                    state_next = S_FINISH;
                else
                begin
                    cmd = CMD_DIGIT;
                    if (!stat.ge)
                    begin
                        if (cnt_reg == '0)
                            state_next = S_FINISH;
                        else
                            cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
            S_FINISH:
            begin
                // The output register is only overwritten once its result has gone.
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = CMD_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_publish_free : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUBLISH) |-> (!out_valid_reg || out_ready))
        else $error("result published over one not yet taken");

    a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_POW && cnt_reg == '0))
        else $error("accepted request did not start the power sweep");

    a_publish_valid : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUBLISH) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("published result not presented");

    a_digit_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT || state_reg == S_POW) |-> (cnt_reg < CW'(CAP)))
        else $error("digit index beyond the digit count");

endmodule
`default_nettype wire
